// File: rtl/hsv_pkg.sv
`default_nettype none

package hsv_pkg;

  // field widths
  localparam int HUE_W  = 16;  // signed hue, 1/64 degree
  localparam int SV_W   = 11;  // signed Q8 saturation / value
  localparam int Q_W    = 9;   // clamped Q8, 0..256
  localparam int M_W    = 15;  // wrapped hue, 0..23039
  localparam int SEC_W  = 3;   // sector, 0..5
  localparam int R_W    = 12;  // remainder inside sector, 0..3839
  localparam int T_W    = 20;  // term numerator over 256*3840
  localparam int N_W    = 28;  // channel numerator over 256*256*3840
  localparam int SCL_W  = 18;  // width of the 255.999 scale numerator
  localparam int Y_W    = 19;  // scaled numerator after the power-of-two part
  localparam int RCP_W  = 20;  // reciprocal of 1875
  localparam int BYTE_W = 8;

  localparam int NUM_STAGES  = 7;
  localparam int NUM_SECTORS = 6;

  localparam int HUE_FULL   = 23040;
  localparam int HUE_SECTOR = 3840;
  localparam int Q8_ONE     = 256;
  localparam int TERM_BASE  = Q8_ONE * HUE_SECTOR;

  // floor(N * 255999 / (2^24*15 * 1000)) = floor(floor(N * 255999 / 2^27) / 1875)
  localparam int SCALE_SHIFT = 27;
  localparam logic [SCL_W-1:0] SCALE_NUM = 18'd255999;
  localparam logic [Y_W-1:0]   DIV_REM   = 19'd1875;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RCP_W-1:0] RECIP     = 20'd572662;  // floor(2^30 / 1875)

  typedef enum logic [1:0] {
    TERM_V,
    TERM_P1,
    TERM_P2,
    TERM_P3
  } term_sel_t;

  typedef struct packed {
    term_sel_t red;
    term_sel_t green;
    term_sel_t blue;
  } route_t;

  // stage 2 -> stage 3 bundle
  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic [R_W-1:0]   r;
    logic [Q_W-1:0]   s;
    logic [Q_W-1:0]   v;
  } hsv_prep_t;

  // per-channel term and value
  typedef struct packed {
    logic [T_W-1:0] t;
    logic [Q_W-1:0] v;
  } chan_term_t;

  function automatic route_t route_lookup(input logic [SEC_W-1:0] sector);
    route_t rt;
    unique case (sector)
      3'd0:    rt = '{red: TERM_V,  green: TERM_P3, blue: TERM_P1};
      3'd1:    rt = '{red: TERM_P2, green: TERM_V,  blue: TERM_P1};
      3'd2:    rt = '{red: TERM_P1, green: TERM_V,  blue: TERM_P3};
      3'd3:    rt = '{red: TERM_P1, green: TERM_P2, blue: TERM_V};
      3'd4:    rt = '{red: TERM_P3, green: TERM_P1, blue: TERM_V};
      default: rt = '{red: TERM_V,  green: TERM_P1, blue: TERM_P2};
    endcase
    return rt;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hsv_if.sv
`default_nettype none

interface hsv_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [hsv_pkg::HUE_W-1:0] hue;
  logic signed [hsv_pkg::SV_W-1:0]  saturation;
  logic signed [hsv_pkg::SV_W-1:0]  brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv_out_if;
  logic                        valid;
  logic                        ready;
  logic [hsv_pkg::BYTE_W-1:0]  red_out;
  logic [hsv_pkg::BYTE_W-1:0]  green_out;
  logic [hsv_pkg::BYTE_W-1:0]  blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

// File: rtl/hsv_hue_prep.sv
`default_nettype none

// Stages 1-2: clamp S/V, wrap hue, split into sector and remainder.
module hsv_hue_prep (
  input  wire logic                             clk,
  input  wire logic [1:0]                       en,
  input  wire logic signed [hsv_pkg::HUE_W-1:0] hue,
  input  wire logic signed [hsv_pkg::SV_W-1:0]  saturation,
  input  wire logic signed [hsv_pkg::SV_W-1:0]  brightness,
  output hsv_pkg::hsv_prep_t                    prep
);

  localparam logic signed [hsv_pkg::HUE_W:0] FULL_S =
    (hsv_pkg::HUE_W+1)'(hsv_pkg::HUE_FULL);
  localparam logic signed [hsv_pkg::HUE_W:0] FULL2_S =
    (hsv_pkg::HUE_W+1)'(2 * hsv_pkg::HUE_FULL);

  function automatic logic [hsv_pkg::Q_W-1:0] clamp_q8(
    input logic signed [hsv_pkg::SV_W-1:0] x
  );
    logic [hsv_pkg::Q_W-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > $signed(hsv_pkg::SV_W'(hsv_pkg::Q8_ONE))) begin
      res = hsv_pkg::Q_W'(hsv_pkg::Q8_ONE);
    end else begin
      res = x[hsv_pkg::Q_W-1:0];
    end
    return res;
  endfunction

  logic [hsv_pkg::Q_W-1:0]          s1, v1;
  logic [hsv_pkg::M_W-1:0]          m1;
  logic signed [hsv_pkg::HUE_W:0]   hx, mx;
  logic [hsv_pkg::SEC_W-1:0]        sec;
  logic [hsv_pkg::M_W-1:0]          sec_base;

  // hue mod 23040, negatives wrapped up
  always_comb begin
    hx = {hue[hsv_pkg::HUE_W-1], hue};
    if (hx < -FULL_S) begin
      mx = hx + FULL2_S;
    end else if (hx < 0) begin
      mx = hx + FULL_S;
    end else if (hx >= FULL_S) begin
      mx = hx - FULL_S;
    end else begin
      mx = hx;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1 <= clamp_q8(saturation);
      v1 <= clamp_q8(brightness);
      m1 <= mx[hsv_pkg::M_W-1:0];
    end
  end

  // independent threshold compares, highest passed wins
  always_comb begin
    sec      = '0;
    sec_base = '0;
    for (int k = 1; k < hsv_pkg::NUM_SECTORS; k++) begin
      if (m1 >= hsv_pkg::M_W'(k * hsv_pkg::HUE_SECTOR)) begin
        sec      = hsv_pkg::SEC_W'(k);
        sec_base = hsv_pkg::M_W'(k * hsv_pkg::HUE_SECTOR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prep.sector <= sec;
      prep.r      <= hsv_pkg::R_W'(m1 - sec_base);
      prep.s      <= s1;
      prep.v      <= v1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hsv_term_route.sv
`default_nettype none

// Stage 3: form V, p1, p2, p3 numerators (over 256*3840) and route by sector.
module hsv_term_route (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire hsv_pkg::hsv_prep_t prep,
  output hsv_pkg::chan_term_t     red,
  output hsv_pkg::chan_term_t     green,
  output hsv_pkg::chan_term_t     blue
);

  logic [hsv_pkg::T_W-1:0] term [4];
  logic [hsv_pkg::T_W-1:0] sr, sq;
  logic [hsv_pkg::Q_W-1:0] one_minus_s;
  logic [hsv_pkg::R_W-1:0] one_minus_r;
  hsv_pkg::route_t         rt;

  always_comb begin
    one_minus_s = hsv_pkg::Q_W'(hsv_pkg::Q8_ONE) - prep.s;
    one_minus_r = hsv_pkg::R_W'(hsv_pkg::HUE_SECTOR) - prep.r;
    sr = hsv_pkg::T_W'(prep.s) * hsv_pkg::T_W'(prep.r);
    sq = hsv_pkg::T_W'(prep.s) * hsv_pkg::T_W'(one_minus_r);
    term[hsv_pkg::TERM_V]  = hsv_pkg::T_W'(hsv_pkg::TERM_BASE);
    term[hsv_pkg::TERM_P1] = hsv_pkg::T_W'(one_minus_s) *
                             hsv_pkg::T_W'(hsv_pkg::HUE_SECTOR);
    term[hsv_pkg::TERM_P2] = hsv_pkg::T_W'(hsv_pkg::TERM_BASE) - sr;
    term[hsv_pkg::TERM_P3] = hsv_pkg::T_W'(hsv_pkg::TERM_BASE) - sq;
    rt = hsv_pkg::route_lookup(prep.sector);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red.t   <= term[rt.red];
      green.t <= term[rt.green];
      blue.t  <= term[rt.blue];
      red.v   <= prep.v;
      green.v <= prep.v;
      blue.v  <= prep.v;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hsv_chan_scale.sv
`default_nettype none

// Stages 4-7 of one channel: N = V*T, then floor(N*255999 / (2^27*1875)).
module hsv_chan_scale (
  input  wire logic                        clk,
  input  wire logic [3:0]                  en,
  input  wire hsv_pkg::chan_term_t         term,
  output logic [hsv_pkg::BYTE_W-1:0]       chan
);

  localparam int NP_W = hsv_pkg::Q_W + hsv_pkg::T_W;
  localparam int XP_W = hsv_pkg::N_W + hsv_pkg::SCL_W;
  localparam int QP_W = hsv_pkg::Y_W + hsv_pkg::RCP_W;

  logic [NP_W-1:0]             prod_n;
  logic [XP_W-1:0]             prod_x;
  logic [QP_W-1:0]             prod_q;
  logic [hsv_pkg::Y_W-1:0]     back, rem;
  logic [hsv_pkg::N_W-1:0]     n;
  logic [hsv_pkg::Y_W-1:0]     y, y2;
  logic [hsv_pkg::BYTE_W-1:0]  q0;

  always_comb begin
    prod_n = NP_W'(term.v) * NP_W'(term.t);
    prod_x = XP_W'(n) * XP_W'(hsv_pkg::SCALE_NUM);
    prod_q = QP_W'(y) * QP_W'(hsv_pkg::RECIP);
    back   = hsv_pkg::Y_W'(q0) * hsv_pkg::DIV_REM;
    rem    = y2 - back;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n <= prod_n[hsv_pkg::N_W-1:0];
    end
    if (en[1]) begin
      y <= prod_x[hsv_pkg::SCALE_SHIFT+hsv_pkg::Y_W-1:hsv_pkg::SCALE_SHIFT];
    end
    // reciprocal estimate is exact or one low
    if (en[2]) begin
      q0 <= prod_q[hsv_pkg::RECIP_SHIFT+hsv_pkg::BYTE_W-1:hsv_pkg::RECIP_SHIFT];
      y2 <= y;
    end
    if (en[3]) begin
      chan <= (rem >= hsv_pkg::DIV_REM) ? q0 + hsv_pkg::BYTE_W'(1) : q0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hsv_to_rgb888_core.sv
// Datapath: an accepted input passes through 7 register stages; the last stage drives
// the outputs and output valid.
// Throughput: one item per clock unless stalled; 7-stage pipeline, per-stage valids.
// Backpressure: a full stage holds while its successor cannot load; empty stages fill
// even when the output is stalled, so up to 7 items sit in flight.
// Reset: synchronous, active high; clears all stage valid bits, data is not reset.
`default_nettype none

module hsv_to_rgb888_core (
  input  wire logic   clk,
  input  wire logic   rst,
  hsv_in_if.sink      hsv,
  hsv_out_if.source   rgb
);

  // Stage map:
  //   0: clamp S and V to [0,256], wrap hue into [0,23040)
  //   1: sector = hue/3840 by threshold compares, remainder r
  //   2: p1/p2/p3 numerators over 256*3840, route to R/G/B by sector
  //   3: per channel N = V * term (exact numerator over 256*256*3840)
  //   4: N * 255999, drop the 2^27 factor of the denominator
  //   5: divide by 1875 via reciprocal multiply (may come out one low)
  //   6: remainder check fixes the low case; this is the output register

  localparam int LAST = hsv_pkg::NUM_STAGES - 1;

  logic [hsv_pkg::NUM_STAGES-1:0] vld;
  logic [hsv_pkg::NUM_STAGES-1:0] en;

  hsv_pkg::hsv_prep_t  prep;
  hsv_pkg::chan_term_t red_term, green_term, blue_term;

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    en[LAST] = !vld[LAST] || rgb.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign hsv.ready = en[0];
  assign rgb.valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= hsv.valid;
      end
      for (int k = 1; k < hsv_pkg::NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  hsv_hue_prep u_hue_prep (
    .clk        (clk),
    .en         (en[1:0]),
    .hue        (hsv.hue),
    .saturation (hsv.saturation),
    .brightness (hsv.brightness),
    .prep       (prep)
  );

  hsv_term_route u_term_route (
    .clk   (clk),
    .en    (en[2]),
    .prep  (prep),
    .red   (red_term),
    .green (green_term),
    .blue  (blue_term)
  );

  hsv_chan_scale u_scale_red (
    .clk  (clk),
    .en   (en[6:3]),
    .term (red_term),
    .chan (rgb.red_out)
  );

  hsv_chan_scale u_scale_green (
    .clk  (clk),
    .en   (en[6:3]),
    .term (green_term),
    .chan (rgb.green_out)
  );

  hsv_chan_scale u_scale_blue (
    .clk  (clk),
    .en   (en[6:3]),
    .term (blue_term),
    .chan (rgb.blue_out)
  );

endmodule

`default_nettype wire

// File: rtl/hsv_to_rgb888_checker.sv
`default_nettype none

module hsv_to_rgb888_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [hsv_pkg::BYTE_W-1:0]  red_out,
  input wire logic [hsv_pkg::BYTE_W-1:0]  green_out,
  input wire logic [hsv_pkg::BYTE_W-1:0]  blue_out
);

  localparam logic [3:0] DEPTH = 4'(hsv_pkg::NUM_STAGES);

  logic [3:0] inflight;
  logic       acc_in, acc_out;

  assign acc_in  = in_valid && in_ready;
  assign acc_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 4'(acc_in) - 4'(acc_out);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({red_out, green_out, blue_out}))
    else $error("stalled output item changed or dropped");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 4'd0)
    else $error("output item with nothing in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= DEPTH)
    else $error("more items in flight than pipeline stages");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    inflight == DEPTH && !out_ready |-> !in_ready)
    else $error("input taken while pipeline full and output stalled");

endmodule

bind hsv_to_rgb888_core hsv_to_rgb888_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (hsv.valid),
  .in_ready  (hsv.ready),
  .out_valid (rgb.valid),
  .out_ready (rgb.ready),
  .red_out   (rgb.red_out),
  .green_out (rgb.green_out),
  .blue_out  (rgb.blue_out)
);

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv_pkg::*;

  // Ends the run if the block hangs.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;  // 7-stage pipeline plus margin
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

  // One expected color plus the HSV item it came from, for diagnostics.
  typedef struct {
    logic signed [HUE_W-1:0] hue;
    logic signed [SV_W-1:0]  sat;
    logic signed [SV_W-1:0]  val;
    rgb_t                    rgb;
  } rgb_pending_t;

  logic clk;
  logic rst;

  hsv_in_if  hsv_ch ();
  hsv_out_if rgb_ch ();

  hsv_to_rgb888_core dut (
    .clk (clk),
    .rst (rst),
    .hsv (hsv_ch),
    .rgb (rgb_ch)
  );

  rgb_pending_t rgb_pending[$];  // colors still owed by the pipeline, oldest first
  int error_count = 0;
  int cycle_count = 0;
  int burst_left;                // items left in the current sender burst

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Color predictor
  // ------------------------------------------------------------------------

  // Q8 clamp to [0, 1.0]
  function automatic int clamp_unit(input int x);
    if (x < 0) return 0;
    if (x > Q8_ONE) return Q8_ONE;
    return x;
  endfunction

  // Fraction num / (256*256*3840) scaled by 255.999 and floored, exactly.
  function automatic logic [BYTE_W-1:0] scale_channel(input longint unsigned num);
    longint unsigned scaled;
    scaled = (num * 64'd255999) / (64'd251658240 * 64'd1000);
    return scaled[BYTE_W-1:0];
  endfunction

  function automatic longint unsigned pick_term(input term_sel_t sel,
                                                input longint unsigned tv, tp1, tp2, tp3);
    case (sel)
      TERM_V:  return tv;
      TERM_P1: return tp1;
      TERM_P2: return tp2;
      default: return tp3;
    endcase
  endfunction

  function automatic rgb_t predict_rgb(input logic signed [HUE_W-1:0] hue,
                                       input logic signed [SV_W-1:0]  sat,
                                       input logic signed [SV_W-1:0]  val);
    int              h, wrapped, s, v;
    int unsigned     sector, rem;
    longint unsigned base, tv, tp1, tp2, tp3;
    term_sel_t       sel_r, sel_g, sel_b;
    rgb_t            res;
    h = hue;
    s = clamp_unit(sat);
    v = clamp_unit(val);
    // wrap hue into one turn; negatives move up
    wrapped = h % HUE_FULL;
    if (wrapped < 0) wrapped += HUE_FULL;
    sector = wrapped / HUE_SECTOR;
    rem    = wrapped % HUE_SECTOR;
    base = longint'(Q8_ONE) * HUE_SECTOR;
    tv  = longint'(v) * base;
    tp1 = longint'(v) * (longint'(Q8_ONE - s) * HUE_SECTOR);
    tp2 = longint'(v) * (base - longint'(s) * rem);
    tp3 = longint'(v) * (base - longint'(s) * (HUE_SECTOR - rem));
    case (sector)
      0: begin sel_r = TERM_V;  sel_g = TERM_P3; sel_b = TERM_P1; end
      1: begin sel_r = TERM_P2; sel_g = TERM_V;  sel_b = TERM_P1; end
      2: begin sel_r = TERM_P1; sel_g = TERM_V;  sel_b = TERM_P3; end
      3: begin sel_r = TERM_P1; sel_g = TERM_P2; sel_b = TERM_V;  end
      4: begin sel_r = TERM_P3; sel_g = TERM_P1; sel_b = TERM_V;  end
      default: begin sel_r = TERM_V; sel_g = TERM_P1; sel_b = TERM_P2; end
    endcase
    res.red   = scale_channel(pick_term(sel_r, tv, tp1, tp2, tp3));
    res.green = scale_channel(pick_term(sel_g, tv, tp1, tp2, tp3));
    res.blue  = scale_channel(pick_term(sel_b, tv, tp1, tp2, tp3));
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them
  // ------------------------------------------------------------------------

  task automatic send_hsv(input logic signed [HUE_W-1:0] hue,
                          input logic signed [SV_W-1:0]  sat,
                          input logic signed [SV_W-1:0]  val);
    int gap;
    rgb_pending_t item;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        hsv_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst, so the pipeline runs back to back
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                              : $urandom_range(1, 12);
    end
    burst_left--;
    hsv_ch.valid      <= 1'b1;
    hsv_ch.hue        <= hue;
    hsv_ch.saturation <= sat;
    hsv_ch.brightness <= val;
    do @(posedge clk); while (!hsv_ch.ready);
    item.hue = hue;
    item.sat = sat;
    item.val = val;
    item.rgb = predict_rgb(hue, sat, val);
    rgb_pending.push_back(item);
  endtask

  // Drop valid and hold off until the pipeline has handed back everything.
  task automatic wait_pipeline_empty();
    hsv_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (rgb_pending.size() != 0);
  endtask

  // ------------------------------------------------------------------------
  // Receiver: ready follows a stall mode that is redrawn at random throughout the run
  // ------------------------------------------------------------------------

  int stall_mode = 0;
  int stall_cycle = 0;

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 128 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: rgb_ch.ready <= 1'b1;                             // no stalls
      1: rgb_ch.ready <= ($urandom_range(0, 3) != 0);      // light random stalls
      2: rgb_ch.ready <= ((stall_cycle % 5) != 4);         // periodic stall
      default: rgb_ch.ready <= ($urandom_range(0, 3) == 0); // heavy stalls
    endcase
  end

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin : check_rgb
    rgb_pending_t want;
    if (!rst && rgb_ch.valid && rgb_ch.ready) begin
      if (rgb_pending.size() == 0) begin
        report_mismatch($sformatf("unexpected color %0d %0d %0d",
                                  rgb_ch.red_out, rgb_ch.green_out, rgb_ch.blue_out));
      end else begin
        want = rgb_pending.pop_front();
        if (rgb_ch.red_out !== want.rgb.red)
          report_mismatch($sformatf("red %0d, want %0d (hsv %0d %0d %0d)", rgb_ch.red_out,
                                    want.rgb.red, want.hue, want.sat, want.val));
        if (rgb_ch.green_out !== want.rgb.green)
          report_mismatch($sformatf("green %0d, want %0d (hsv %0d %0d %0d)", rgb_ch.green_out,
                                    want.rgb.green, want.hue, want.sat, want.val));
        if (rgb_ch.blue_out !== want.rgb.blue)
          report_mismatch($sformatf("blue %0d, want %0d (hsv %0d %0d %0d)", rgb_ch.blue_out,
                                    want.rgb.blue, want.hue, want.sat, want.val));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d colors outstanding", rgb_pending.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Field extremes, clamping, hue wrap, zero value, zero saturation.
  task automatic test_special_cases();
    send_hsv(16'sh8000, 11'sd256, 11'sd256);        // most negative hue
    send_hsv(16'sh7FFF, 11'sd256, 11'sd256);        // most positive hue
    send_hsv(-16'sd1, 11'sd256, 11'sd256);          // just below zero wraps to top
    send_hsv(-16'sd23040, 11'sd200, 11'sd180);      // minus one full turn
    send_hsv(16'sd23040, 11'sd200, 11'sd180);       // exactly one turn
    send_hsv(16'sd1000, 11'sh400, 11'sd256);        // saturation clamps to zero
    send_hsv(16'sd1000, 11'sd1023, 11'sd256);       // saturation clamps to one
    send_hsv(16'sd9000, 11'sd128, 11'sh400);        // value clamps to zero
    send_hsv(16'sd9000, 11'sd128, 11'sd1023);       // value clamps to one
    send_hsv(16'sd5000, 11'sd257, -11'sd1);         // one past each clamp edge
    send_hsv(16'sd12345, 11'sd256, 11'sd0);         // zero value: black
    send_hsv(16'sd12345, 11'sd0, 11'sd173);         // zero saturation: gray
    send_hsv(16'sd0, 11'sd0, 11'sd256);             // white
  endtask

  // Each sector at its first unit, and the last unit before each boundary.
  task automatic test_sector_edges();
    for (int k = 0; k < NUM_SECTORS; k++)
      send_hsv(HUE_W'(k * HUE_SECTOR), 11'sd256, 11'sd256);
    for (int k = 1; k <= NUM_SECTORS; k++)
      send_hsv(HUE_W'(k * HUE_SECTOR - 1), 11'sd255, 11'sd255);
  endtask

  function automatic logic signed [SV_W-1:0] random_q8();
    case ($urandom_range(0, 9))
      0, 1:    return SV_W'($urandom);                  // any code, clamps included
      2:       return ($urandom_range(0, 1) != 0) ? 11'sd256 : 11'sd0;
      default: return SV_W'($urandom_range(0, Q8_ONE));
    endcase
  endfunction

  function automatic logic signed [HUE_W-1:0] random_hue();
    int h;
    case ($urandom_range(0, 7))
      0, 1: begin
        // near a sector boundary, sometimes one turn down
        h = $urandom_range(0, NUM_SECTORS) * HUE_SECTOR + $urandom_range(0, 4) - 2;
        if ($urandom_range(0, 1) != 0) h -= HUE_FULL;
        return HUE_W'(h);
      end
      2:       return HUE_W'($urandom_range(0, HUE_FULL - 1));
      default: return HUE_W'($urandom);
    endcase
  endfunction

  task automatic test_random_colors(input int count);
    for (int i = 0; i < count; i++)
      send_hsv(random_hue(), random_q8(), random_q8());
  endtask

  // Stop feeding mid-run until the pipeline has emptied, then carry on.
  task automatic test_drain_pause();
    wait_pipeline_empty();
    send_hsv(16'sd2000, 11'sd256, 11'sd256);
  endtask

  initial begin
    rst               <= 1'b1;
    hsv_ch.valid      <= 1'b0;
    hsv_ch.hue        <= '0;
    hsv_ch.saturation <= '0;
    hsv_ch.brightness <= '0;
    burst_left        = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_cases();
    test_sector_edges();
    test_random_colors(800);
    test_drain_pause();
    test_random_colors(850);

    wait_pipeline_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: hsv_to_rgb888_core.f
rtl/hsv_pkg.sv
rtl/hsv_if.sv
rtl/hsv_hue_prep.sv
rtl/hsv_term_route.sv
rtl/hsv_chan_scale.sv
rtl/hsv_to_rgb888_core.sv
rtl/hsv_to_rgb888_checker.sv
tb/sv/tb.sv
